[rtl/core/vrp_pkg.sv]
package vrp_pkg;

  localparam int CW = 16;
  localparam int SW = 12;
  localparam int QB = SW;
  localparam int PW = 50;

  localparam logic [QB-1:0] Q_POS_MAX = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] Q_NEG_MAX = {1'b1, {(QB-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_DEPTH  = 3'd2,
    REG_ZOOM   = 3'd3,
    REG_CX     = 3'd4,
    REG_CY     = 3'd5
  } reg_idx_t;

  typedef logic [PW-1:0] mag_t;

  typedef struct packed {
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic signed [15:0] depth_offset;
    logic [11:0]        zoom;
    logic [10:0]        org_x;
    logic [10:0]        org_y;
  } cfg_t;

  typedef struct packed {
    mag_t num_x;
    mag_t num_y;
    mag_t den;
    logic neg_x;
    logic neg_y;
    logic zero;
  } divreq_t;

  typedef struct packed {
    mag_t          rem_x;
    mag_t          rem_y;
    mag_t          den;
    logic [QB-1:0] q_x;
    logic [QB-1:0] q_y;
    logic          ovf_x;
    logic          ovf_y;
    logic          neg_x;
    logic          neg_y;
    logic          zero;
  } divstage_t;

endpackage

[rtl/core/vrp_if.sv]
interface vrp_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [vrp_pkg::CW-1:0]    point_x;
  logic signed [vrp_pkg::CW-1:0]    point_y;
  logic signed [vrp_pkg::CW-1:0]    point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface vrp_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [vrp_pkg::SW-1:0]    pos_x;
  logic signed [vrp_pkg::SW-1:0]    pos_y;
  logic                             clipped;
  logic                             zero_depth;
  modport source (output valid, pos_x, pos_y, clipped, zero_depth, input ready);
  modport sink (input valid, pos_x, pos_y, clipped, zero_depth, output ready);
endinterface

[rtl/core/vrp_xform.sv]
module vrp_xform (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  vrp_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  logic signed [vrp_pkg::CW-1:0] x,
  input  logic signed [vrp_pkg::CW-1:0] y,
  input  logic signed [vrp_pkg::CW-1:0] z,
  output logic                          out_valid,
  output vrp_pkg::divreq_t              req
);

  logic [4:0] vld;

  logic signed [31:0] p_cx, p_sz, p_sx, p_cz;
  logic signed [15:0] y1;
  logic signed [32:0] rx;
  logic signed [29:0] ry;
  logic signed [33:0] dep2, dep3, dep4;
  logic signed [45:0] m_cxd, m_rz, m_cyd;
  logic signed [42:0] m_ryz;
  logic signed [vrp_pkg::PW-1:0] nx, ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cx  <= cfg.cos_angle * x;
      p_sz  <= cfg.sin_angle * z;
      p_sx  <= cfg.sin_angle * x;
      p_cz  <= cfg.cos_angle * z;
      y1    <= y;
      rx    <= 33'(p_cx) - 33'(p_sz);
      ry    <= {y1, 14'd0};
      dep2  <= 34'(p_sx) + 34'(p_cz) + 34'($signed({cfg.depth_offset, 14'd0}));
      m_cxd <= $signed({1'b0, cfg.org_x}) * dep2;
      m_rz  <= rx * $signed({1'b0, cfg.zoom});
      m_cyd <= $signed({1'b0, cfg.org_y}) * dep2;
      m_ryz <= ry * $signed({1'b0, cfg.zoom});
      dep3  <= dep2;
      nx    <= vrp_pkg::PW'(m_cxd) - vrp_pkg::PW'(m_rz);
      ny    <= vrp_pkg::PW'(m_cyd) + vrp_pkg::PW'(m_ryz);
      dep4  <= dep3;
      req.num_x <= nx[vrp_pkg::PW-1] ? vrp_pkg::mag_t'(-nx) : vrp_pkg::mag_t'(nx);
      req.num_y <= ny[vrp_pkg::PW-1] ? vrp_pkg::mag_t'(-ny) : vrp_pkg::mag_t'(ny);
      req.den   <= dep4[33] ? vrp_pkg::mag_t'(-vrp_pkg::PW'(dep4))
                            : vrp_pkg::mag_t'(vrp_pkg::PW'(dep4));
      req.neg_x <= nx[vrp_pkg::PW-1] ^ dep4[33];
      req.neg_y <= ny[vrp_pkg::PW-1] ^ dep4[33];
      req.zero  <= (dep4 == '0);
    end
  end

  assign out_valid = vld[4];

endmodule

[rtl/core/vrp_div.sv]
module vrp_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  vrp_pkg::divreq_t     req,
  output logic                 out_valid,
  output vrp_pkg::divstage_t   res
);

  vrp_pkg::divstage_t st [0:vrp_pkg::QB];
  logic [vrp_pkg::QB:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[vrp_pkg::QB-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].rem_x <= req.num_x;
      st[0].rem_y <= req.num_y;
      st[0].den   <= req.den;
      st[0].q_x   <= '0;
      st[0].q_y   <= '0;
      st[0].ovf_x <= req.num_x >= (req.den << vrp_pkg::QB);
      st[0].ovf_y <= req.num_y >= (req.den << vrp_pkg::QB);
      st[0].neg_x <= req.neg_x;
      st[0].neg_y <= req.neg_y;
      st[0].zero  <= req.zero;
    end
  end

  for (genvar j = 1; j <= vrp_pkg::QB; j++) begin : g_step
    vrp_pkg::mag_t      sd;
    logic               tx, ty;
    vrp_pkg::divstage_t nxt;
    assign sd = st[j-1].den << (vrp_pkg::QB - j);
    assign tx = st[j-1].rem_x >= sd;
    assign ty = st[j-1].rem_y >= sd;
    always_comb begin
      nxt = st[j-1];
      nxt.rem_x = tx ? st[j-1].rem_x - sd : st[j-1].rem_x;
      nxt.rem_y = ty ? st[j-1].rem_y - sd : st[j-1].rem_y;
      nxt.q_x[vrp_pkg::QB-j] = tx;
      nxt.q_y[vrp_pkg::QB-j] = ty;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[j] <= nxt;
      end
    end
  end

  assign res       = st[vrp_pkg::QB];
  assign out_valid = vld[vrp_pkg::QB];

endmodule

[rtl/core/vertex_rotate_project_unit.sv]
// Vertex rotate and project unit.
// Input channel "vertex" carries one vertex (point_x/y/z, signed Q4.12)
// per word; output channel "pixel" returns one screen position per vertex
// with clipped and zero_depth flags, in input order.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while no vertex is in flight (the block does not enforce
// this); unknown indexes are dropped. Throughput: one vertex per cycle while
// the receiver takes words; each vertex passes through 19 register
// stages: 5 transform stages (products, rotate, scale, sums, magnitudes),
// 13 divider stages (range check plus one quotient bit per stage for both
// coordinates against the shared depth), 1 saturation stage.
// The whole pipeline advances together; when the receiver holds ready low
// with a word waiting, every stage holds and vertex.ready drops.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults: cos 1.0, sin 0, depth offset -6.0, zoom 450, center (400,300).
module vertex_rotate_project_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [15:0]                 cfg_data,
  vrp_in_if.sink                      vertex,
  vrp_out_if.source                   pixel
);

  vrp_pkg::cfg_t      cfg;
  vrp_pkg::divreq_t   req;
  vrp_pkg::divstage_t res;
  logic               en, x_valid, d_valid;
  logic               sat_xh, sat_xl, sat_yh, sat_yl;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_angle    <= 16'sd16384;
      cfg.sin_angle    <= 16'sd0;
      cfg.depth_offset <= -16'sd24576;
      cfg.zoom         <= 12'd450;
      cfg.org_x        <= 11'd400;
      cfg.org_y        <= 11'd300;
    end else if (cfg_we) begin
      case (cfg_index)
        vrp_pkg::REG_COS:   cfg.cos_angle    <= cfg_data;
        vrp_pkg::REG_SIN:   cfg.sin_angle    <= cfg_data;
        vrp_pkg::REG_DEPTH: cfg.depth_offset <= cfg_data;
        vrp_pkg::REG_ZOOM:  cfg.zoom         <= cfg_data[11:0];
        vrp_pkg::REG_CX:    cfg.org_x        <= cfg_data[10:0];
        vrp_pkg::REG_CY:    cfg.org_y        <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign en           = !pixel.valid || pixel.ready;
  assign vertex.ready = en;

  vrp_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (vertex.valid),
    .x         (vertex.point_x),
    .y         (vertex.point_y),
    .z         (vertex.point_z),
    .out_valid (x_valid),
    .req       (req)
  );

  vrp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (x_valid),
    .req       (req),
    .out_valid (d_valid),
    .res       (res)
  );

  assign sat_xh = !res.neg_x && (res.ovf_x || res.q_x > vrp_pkg::Q_POS_MAX);
  assign sat_xl = res.neg_x && (res.ovf_x || res.q_x > vrp_pkg::Q_NEG_MAX);
  assign sat_yh = !res.neg_y && (res.ovf_y || res.q_y > vrp_pkg::Q_POS_MAX);
  assign sat_yl = res.neg_y && (res.ovf_y || res.q_y > vrp_pkg::Q_NEG_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (en) begin
      pixel.valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (res.zero) begin
        pixel.pos_x      <= '0;
        pixel.pos_y      <= '0;
        pixel.clipped    <= 1'b0;
        pixel.zero_depth <= 1'b1;
      end else begin
        pixel.pos_x      <= sat_xh ? vrp_pkg::Q_POS_MAX :
                            sat_xl ? vrp_pkg::Q_NEG_MAX :
                            res.neg_x ? -res.q_x : res.q_x;
        pixel.pos_y      <= sat_yh ? vrp_pkg::Q_POS_MAX :
                            sat_yl ? vrp_pkg::Q_NEG_MAX :
                            res.neg_y ? -res.q_y : res.q_y;
        pixel.clipped    <= sat_xh || sat_xl || sat_yh || sat_yl;
        pixel.zero_depth <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_zero_quiet: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.zero_depth |->
      pixel.pos_x == '0 && pixel.pos_y == '0 && !pixel.clipped)
    else $error("zero depth word carries data");

  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.clipped |->
      pixel.pos_x == vrp_pkg::Q_POS_MAX || pixel.pos_x == vrp_pkg::Q_NEG_MAX ||
      pixel.pos_y == vrp_pkg::Q_POS_MAX || pixel.pos_y == vrp_pkg::Q_NEG_MAX)
    else $error("clipped word not at a limit");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && !pixel.ready |=> pixel.valid && $stable(pixel.pos_x)
      && $stable(pixel.pos_y) && $stable(pixel.clipped) && $stable(pixel.zero_depth))
    else $error("output word changed while stalled");
`endif

endmodule

[dv/tb_vertex_rotate_project_unit.sv]
module tb_vertex_rotate_project_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [vrp_pkg::SW-1:0] sx;
    logic signed [vrp_pkg::SW-1:0] sy;
    logic                          clip;
    logic                          zdep;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  vrp_in_if vtx ();
  vrp_out_if pix ();

  vertex_rotate_project_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .vertex(vtx.sink), .pixel(pix.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers
  logic signed [15:0] m_cos, m_sin, m_depth;
  logic [11:0] m_zoom;
  logic [10:0] m_cx, m_cy;

  pixel_t pixel_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_clip = 0;
  int n_zero = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit gaps_on = 1'b1;

  function automatic logic signed [vrp_pkg::SW-1:0] sat_pixel(longint v, ref logic clip);
    if (v > 2047) begin
      clip = 1'b1;
      return 12'sd2047;
    end
    if (v < -2048) begin
      clip = 1'b1;
      return -12'sd2048;
    end
    return v[vrp_pkg::SW-1:0];
  endfunction

  function automatic pixel_t project(logic signed [15:0] x, logic signed [15:0] y,
                                     logic signed [15:0] z);
    longint rx, ry, d, nx, ny;
    pixel_t p;
    logic clip;
    clip = 1'b0;
    rx = longint'(m_cos) * x - longint'(m_sin) * z;
    ry = longint'(y) * 16384;
    d = longint'(m_sin) * x + longint'(m_cos) * z + longint'(m_depth) * 16384;
    if (d == 0) begin
      p = '{sx: '0, sy: '0, clip: 1'b0, zdep: 1'b1};
      return p;
    end
    nx = longint'(m_cx) * d - rx * longint'(m_zoom);
    ny = longint'(m_cy) * d + ry * longint'(m_zoom);
    p.sx = sat_pixel(nx / d, clip);
    p.sy = sat_pixel(ny / d, clip);
    p.clip = clip;
    p.zdep = 1'b0;
    return p;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, a few long ones, plus a long hold-off window
  initial begin
    int stall;
    stall = 0;
    pix.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) pix.ready <= 1'b0;
      else if (gaps_on) begin
        if (stall > 0) begin
          stall--;
          pix.ready <= 1'b0;
        end else if ($urandom_range(0, 40) == 0) begin
          stall = $urandom_range(10, 40);
          pix.ready <= 1'b0;
        end else pix.ready <= ($urandom_range(0, 9) < 7);
      end else pix.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pixel_t exp_p;
    if (!rst && pix.valid && pix.ready) begin
      n_got++;
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: pixel word with nothing expected: %0d %0d %b %b", $time,
                 pix.pos_x, pix.pos_y, pix.clipped, pix.zero_depth);
      end else begin
        exp_p = pixel_q.pop_front();
        if (exp_p.sx !== pix.pos_x) begin
          errors++;
          $display("%0t: pos_x exp %0d got %0d", $time, exp_p.sx, pix.pos_x);
        end
        if (exp_p.sy !== pix.pos_y) begin
          errors++;
          $display("%0t: pos_y exp %0d got %0d", $time, exp_p.sy, pix.pos_y);
        end
        if (exp_p.clip !== pix.clipped) begin
          errors++;
          $display("%0t: clipped exp %b got %b", $time, exp_p.clip, pix.clipped);
        end
        if (exp_p.zdep !== pix.zero_depth) begin
          errors++;
          $display("%0t: zero_depth exp %b got %b", $time, exp_p.zdep, pix.zero_depth);
        end
      end
    end
  end

  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    pixel_t p;
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      vtx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx.valid <= 1'b1;
    vtx.point_x <= x;
    vtx.point_y <= y;
    vtx.point_z <= z;
    do @(posedge clk); while (!vtx.ready);
    p = project(x, y, z);
    pixel_q.push_back(p);
    n_sent++;
    if (p.clip) n_clip++;
    if (p.zdep) n_zero++;
  endtask

  task automatic drain();
    vtx.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(vrp_pkg::reg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      vrp_pkg::REG_COS:   m_cos = val;
      vrp_pkg::REG_SIN:   m_sin = val;
      vrp_pkg::REG_DEPTH: m_depth = val;
      vrp_pkg::REG_ZOOM:  m_zoom = val[11:0];
      vrp_pkg::REG_CX:    m_cx = val[10:0];
      vrp_pkg::REG_CY:    m_cy = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_view(logic [15:0] c, logic [15:0] s, logic [15:0] d,
                          logic [15:0] zm, logic [15:0] cx, logic [15:0] cy);
    write_reg(vrp_pkg::REG_COS, c);
    write_reg(vrp_pkg::REG_SIN, s);
    write_reg(vrp_pkg::REG_DEPTH, d);
    write_reg(vrp_pkg::REG_ZOOM, zm);
    write_reg(vrp_pkg::REG_CX, cx);
    write_reg(vrp_pkg::REG_CY, cy);
  endtask

  task automatic send_random_vertex(bit near);
    logic signed [15:0] x, y, z;
    if (near) begin
      x = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
      y = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
      z = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
      z = 16'($urandom);
    end
    send_vertex(x, y, z);
  endtask

  task automatic test_reset_view();
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(16'sd4096, -16'sd4096, 16'sd0);
    send_vertex(16'sd32767, 16'sd32767, 16'sd32767);
    send_vertex(-16'sd32768, -16'sd32768, -16'sd32768);
    send_vertex(16'sd0, 16'sd100, 16'sd24576);   // depth exactly zero
    send_vertex(16'sd1, -16'sd1, 16'sd24575);    // tiny depth, does not clip
    send_vertex(-16'sd1, 16'sd1, 16'sd24577);
    drain();
  endtask

  task automatic test_extreme_regs();
    set_view(16'h8000, 16'h7fff, 16'h7fff, 16'hfff, 16'h7ff, 16'h7ff);
    send_vertex(16'sd32767, -16'sd32768, 16'sd32767);
    send_vertex(-16'sd32768, 16'sd32767, -16'sd32768);
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    drain();
    set_view(16'h7fff, 16'h8000, 16'h8000, 16'h000, 16'h000, 16'h000);
    send_vertex(16'sd32767, 16'sd32767, 16'sd32767);
    send_vertex(-16'sd12, 16'sd5, -16'sd32768);
    drain();
    // 90 degrees: depth comes from x only
    set_view(16'h0000, 16'h4000, 16'h0000, 16'd450, 16'd400, 16'd300);
    send_vertex(16'sd0, 16'sd4096, 16'sd1234);   // zero depth
    send_vertex(16'sd4096, 16'sd4096, 16'sd0);
    send_vertex(-16'sd4096, -16'sd4096, 16'sd0);
    // unknown index is dropped
    drain();
    cfg_we <= 1'b1;
    cfg_index <= 3'd7;
    cfg_data <= 16'h1234;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_vertex(16'sd4096, 16'sd8, 16'sd77);
    drain();
  endtask

  task automatic test_random_views();
    for (int ph = 0; ph < 6; ph++) begin
      set_view(16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      if (ph == 0) set_view(16'h4000, 16'h0000, 16'h9ffa, 16'd450, 16'd400, 16'd300);
      gaps_on = (ph != 3);
      for (int i = 0; i < 65; i++) send_random_vertex($urandom_range(0, 3) != 0);
      drain();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_view(16'h2d41, 16'hd2bf, 16'ha000, 16'd450, 16'd400, 16'd300);
    fork
      begin
        hold_off = 1'b1;
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_random_vertex(1'b1);
    join
    drain();
  endtask

  initial begin
    vtx.valid = 1'b0;
    vtx.point_x = '0;
    vtx.point_y = '0;
    vtx.point_z = '0;
    m_cos = 16'sd16384;
    m_sin = 16'sd0;
    m_depth = -16'sd24576;
    m_zoom = 12'd450;
    m_cx = 11'd400;
    m_cy = 11'd300;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_view();
    test_extreme_regs();
    test_random_views();
    test_backpressure();
    $display("Sent %0d vertices, checked %0d pixels (%0d clipped, %0d zero depth)",
             n_sent, n_got, n_clip, n_zero);
    $display("Covered reset view, register extremes, random views and a long output stall");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
